// ===== rtl/wavp_pkg.sv =====
// ----------------------------------------------------------------------------
// wavp_pkg
// Types, codes and constants shared by the WAV header stream parser.
// ----------------------------------------------------------------------------
package wavp_pkg;

    localparam int HEADER_BYTES = 36;
    localparam int HCNT_W       = $clog2(HEADER_BYTES + 1);
    localparam int CHUNK_BYTES  = 8;
    localparam int CCNT_W       = $clog2(CHUNK_BYTES);

    localparam logic [HCNT_W-1:0] HDR_LAST     = HCNT_W'(HEADER_BYTES - 1);
    localparam logic [HCNT_W-1:0] OFS_CHANNELS = HCNT_W'(22);
    localparam logic [HCNT_W-1:0] OFS_RATE0    = HCNT_W'(24);
    localparam logic [HCNT_W-1:0] OFS_RATE1    = HCNT_W'(25);
    localparam logic [HCNT_W-1:0] OFS_RATE2    = HCNT_W'(26);
    localparam logic [HCNT_W-1:0] OFS_RATE3    = HCNT_W'(27);
    localparam logic [HCNT_W-1:0] OFS_BITS     = HCNT_W'(34);

    localparam logic [15:0] BITS_16     = 16'd16;
    localparam logic [7:0]  MONO        = 8'd1;
    localparam logic [7:0]  STEREO      = 8'd2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CHUNK   = 2'd1,
        PH_PCM     = 2'd2,
        PH_DISCARD = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_HEADER  = 3'd0,
        ST_FORMAT  = 3'd1,
        ST_CHUNK   = 3'd2,
        ST_PCM     = 3'd3,
        ST_INVALID = 3'd4,
        ST_DISCARD = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_start;
    } t_in_beat;

    typedef struct packed {
        logic       check;
        logic [7:0] expect_byte;
    } t_tag_chk;

    // "RIFF" at offset 0, "WAVE" at offset 8
    function automatic t_tag_chk hdr_tag(input logic [HCNT_W-1:0] idx);
        t_tag_chk r;
        r = '{check: 1'b1, expect_byte: 8'h00};
        case (idx)
            HCNT_W'(0):  r.expect_byte = 8'h52;
            HCNT_W'(1):  r.expect_byte = 8'h49;
            HCNT_W'(2):  r.expect_byte = 8'h46;
            HCNT_W'(3):  r.expect_byte = 8'h46;
            HCNT_W'(8):  r.expect_byte = 8'h57;
            HCNT_W'(9):  r.expect_byte = 8'h41;
            HCNT_W'(10): r.expect_byte = 8'h56;
            HCNT_W'(11): r.expect_byte = 8'h45;
            default:     r.check = 1'b0;
        endcase
        return r;
    endfunction

    // "data" in the first four bytes of a chunk header
    function automatic t_tag_chk chunk_tag(input logic [CCNT_W-1:0] idx);
        t_tag_chk r;
        r = '{check: 1'b1, expect_byte: 8'h00};
        case (idx)
            CCNT_W'(0): r.expect_byte = 8'h64;
            CCNT_W'(1): r.expect_byte = 8'h61;
            CCNT_W'(2): r.expect_byte = 8'h74;
            CCNT_W'(3): r.expect_byte = 8'h61;
            default:    r.check = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/wavp_if.sv =====
// ----------------------------------------------------------------------------
// wavp channel interfaces
// Valid/ready channels for stream bytes in and parse results out.
// ----------------------------------------------------------------------------
interface wavp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       stream_start;

    modport source (output valid, output stream_byte, output stream_start, input ready);
    modport sink   (input valid, input stream_byte, input stream_start, output ready);
endinterface

interface wavp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  pcm_byte;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [7:0]  channel_count;
    logic        mono_expand;

    modport source (
        output valid, output status, output pcm_byte, output sample_rate,
        output bits_per_sample, output channel_count, output mono_expand,
        input ready
    );
    modport sink (
        input valid, input status, input pcm_byte, input sample_rate,
        input bits_per_sample, input channel_count, input mono_expand,
        output ready
    );
endinterface

// ===== rtl/wavp_in_reg.sv =====
// ----------------------------------------------------------------------------
// wavp_in_reg
// Input register: holds one stream beat until the parse stage takes it.
// ----------------------------------------------------------------------------
module wavp_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    wavp_in_if.sink            i_in,
    input  logic               i_take,
    output logic               o_valid,
    output wavp_pkg::t_in_beat o_beat
);
    import wavp_pkg::*;

    logic     r_valid;
    t_in_beat r_beat;

    assign i_in.ready = !r_valid || i_take;
    assign o_valid    = r_valid;
    assign o_beat     = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_beat.stream_byte  <= i_in.stream_byte;
            r_beat.stream_start <= i_in.stream_start;
        end
    end

endmodule

// ===== rtl/wavp_core.sv =====
// ----------------------------------------------------------------------------
// wavp_core
// Parse state and result register: header checks, chunk skip, PCM pass.
// ----------------------------------------------------------------------------
module wavp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  wavp_pkg::t_in_beat i_beat,
    output logic               o_take,
    wavp_out_if.source         o_out
);
    import wavp_pkg::*;

    // parse state
    t_phase            r_phase,    n_phase;
    logic [HCNT_W-1:0] r_hcnt,     n_hcnt;
    logic [CCNT_W-1:0] r_ccnt,     n_ccnt;
    logic [31:0]       r_skip,     n_skip;
    logic              r_hdr_ok,   n_hdr_ok;
    logic              r_data_ok,  n_data_ok;
    logic [7:0]        r_chan,     n_chan;
    logic [31:0]       r_rate,     n_rate;
    logic [7:0]        r_bits_lo,  n_bits_lo;
    logic [23:0]       r_size,     n_size;

    // result register
    logic              r_out_valid;
    t_status           r_status,   n_status;
    logic [7:0]        r_pcm,      n_pcm;
    logic [31:0]       r_o_rate,   n_o_rate;
    logic [15:0]       r_o_bits,   n_o_bits;
    logic [7:0]        r_o_chan,   n_o_chan;
    logic              r_o_exp,    n_o_exp;

    t_phase            cur_phase;
    logic [HCNT_W-1:0] cur_hcnt;
    logic [CCNT_W-1:0] cur_ccnt;
    logic [31:0]       cur_skip;
    logic [7:0]        b;
    t_tag_chk          htag;
    t_tag_chk          ctag;
    logic [15:0]       bps;

    assign o_take = i_valid && (!r_out_valid || o_out.ready);

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.pcm_byte        = r_pcm;
    assign o_out.sample_rate     = r_o_rate;
    assign o_out.bits_per_sample = r_o_bits;
    assign o_out.channel_count   = r_o_chan;
    assign o_out.mono_expand     = r_o_exp;

    always_comb begin
        b         = i_beat.stream_byte;
        cur_phase = i_beat.stream_start ? PH_HEADER : r_phase;
        cur_hcnt  = i_beat.stream_start ? '0 : r_hcnt;
        cur_ccnt  = i_beat.stream_start ? '0 : r_ccnt;
        cur_skip  = i_beat.stream_start ? '0 : r_skip;
        htag      = hdr_tag(cur_hcnt);
        ctag      = chunk_tag(cur_ccnt);
        bps       = {b, r_bits_lo};

        n_phase   = cur_phase;
        n_hcnt    = cur_hcnt;
        n_ccnt    = cur_ccnt;
        n_skip    = cur_skip;
        n_hdr_ok  = r_hdr_ok;
        n_data_ok = r_data_ok;
        n_chan    = r_chan;
        n_rate    = r_rate;
        n_bits_lo = r_bits_lo;
        n_size    = r_size;

        n_status  = ST_DISCARD;
        n_pcm     = '0;
        n_o_rate  = '0;
        n_o_bits  = '0;
        n_o_chan  = '0;
        n_o_exp   = 1'b0;

        unique case (cur_phase)
            PH_HEADER: begin
                n_status = ST_HEADER;
                n_hdr_ok = ((cur_hcnt == '0) || r_hdr_ok)
                         && (!htag.check || (b == htag.expect_byte));
                if (cur_hcnt == OFS_CHANNELS) n_chan         = b;
                if (cur_hcnt == OFS_RATE0)    n_rate[7:0]    = b;
                if (cur_hcnt == OFS_RATE1)    n_rate[15:8]   = b;
                if (cur_hcnt == OFS_RATE2)    n_rate[23:16]  = b;
                if (cur_hcnt == OFS_RATE3)    n_rate[31:24]  = b;
                if (cur_hcnt == OFS_BITS)     n_bits_lo      = b;
                n_hcnt = cur_hcnt + HCNT_W'(1);
                if (cur_hcnt == HDR_LAST) begin
                    if (!n_hdr_ok) begin
                        n_phase  = PH_DISCARD;
                        n_status = ST_INVALID;
                    end else begin
                        n_phase  = PH_CHUNK;
                        n_status = ST_FORMAT;
                        n_o_rate = r_rate;
                        n_o_bits = bps;
                        n_o_exp  = (bps == BITS_16) && (r_chan == MONO);
                        n_o_chan = n_o_exp ? STEREO : r_chan;
                    end
                end
            end
            PH_CHUNK: begin
                n_status = ST_CHUNK;
                if (cur_skip != '0) begin
                    n_skip = cur_skip - 32'd1;
                end else begin
                    n_data_ok = ((cur_ccnt == '0) || r_data_ok)
                              && (!ctag.check || (b == ctag.expect_byte));
                    if (cur_ccnt == CCNT_W'(4)) n_size[7:0]   = b;
                    if (cur_ccnt == CCNT_W'(5)) n_size[15:8]  = b;
                    if (cur_ccnt == CCNT_W'(6)) n_size[23:16] = b;
                    n_ccnt = cur_ccnt + CCNT_W'(1);
                    if (cur_ccnt == CCNT_W'(CHUNK_BYTES - 1)) begin
                        if (n_data_ok) begin
                            n_phase = PH_PCM;
                        end else begin
                            n_skip = {b, r_size};
                        end
                    end
                end
            end
            PH_PCM: begin
                n_status = ST_PCM;
                n_pcm    = b;
            end
            PH_DISCARD: begin
                n_status = ST_DISCARD;
            end
            default: begin
                n_status = ST_DISCARD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hcnt      <= '0;
            r_ccnt      <= '0;
            r_skip      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_phase <= n_phase;
                r_hcnt  <= n_hcnt;
                r_ccnt  <= n_ccnt;
                r_skip  <= n_skip;
            end
            if (!r_out_valid || o_out.ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_hdr_ok  <= n_hdr_ok;
            r_data_ok <= n_data_ok;
            r_chan    <= n_chan;
            r_rate    <= n_rate;
            r_bits_lo <= n_bits_lo;
            r_size    <= n_size;
            r_status  <= n_status;
            r_pcm     <= n_pcm;
            r_o_rate  <= n_o_rate;
            r_o_bits  <= n_o_bits;
            r_o_chan  <= n_o_chan;
            r_o_exp   <= n_o_exp;
        end
    end

endmodule

// ===== rtl/wav_header_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// wav_header_stream_parser_top
// WAV byte stream parser: header check, format report, chunk skip, PCM pass.
//
//   channel   dir   payload                                   beat
//   i_in      in    stream_byte, stream_start                 one stream byte
//   o_out     out   status, pcm_byte, sample_rate,            one result
//                   bits_per_sample, channel_count, mono_expand
//
// One beat per cycle sustained while o_out is ready; each result passes the input
// register, then the parse logic into the result register. Reset clears the parse
// phase and counters and both stage valids; stream_start restarts parsing at the
// beat that carries it. A stalled o_out holds its result and the input register
// keeps taking beats until it is full.
// ----------------------------------------------------------------------------
module wav_header_stream_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wavp_in_if.sink    i_in,
    wavp_out_if.source o_out
);
    import wavp_pkg::*;

    logic     in_valid;
    logic     take;
    t_in_beat in_beat;

    wavp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (in_valid),
        .o_beat  (in_beat)
    );

    wavp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_beat  (in_beat),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule
